### rtl/core/sfa_pkg.sv
// sfa_pkg: shared constants, widths and the operation code type for the
// secp256k1 field ALU. No dependencies.
package sfa_pkg;

  localparam int WORD_W  = 64;
  localparam int FIELD_W = 256;
  localparam int LIMB_W  = 32;
  localparam int NLIMB   = FIELD_W / LIMB_W;
  localparam int PROD_W  = 2 * FIELD_W;

  // p = 2^256 - 2^32 - 977
  localparam logic [FIELD_W-1:0] PRIME =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEFFFFFC2F;

  // 2^256 mod p = 2^32 + 977
  localparam int            FOLD_W   = 33;
  localparam logic [32:0]   FOLD_C   = 33'h1_0000_03D1;
  localparam int            LOWC_W   = 10;
  localparam logic [9:0]    FOLD_LOW = 10'd977;

  // Widths after each reduction fold
  localparam int F1_W = 290;
  localparam int F2_W = 257;
  localparam int F3_W = 257;

  // Register stages from input to output register
  localparam int NSTG = 10;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_DBL = 2'd2,
    OP_MUL = 2'd3
  } op_t;

endpackage

### rtl/core/sfa_addsub.sv
// sfa_addsub: two-stage modular add, subtract and double.
// Depends on sfa_pkg.
module sfa_addsub (
  input  logic                        clk,
  input  logic [1:0]                  ld,
  input  sfa_pkg::op_t                kind,
  input  logic [sfa_pkg::FIELD_W-1:0] a,
  input  logic [sfa_pkg::FIELD_W-1:0] b,
  output logic [sfa_pkg::FIELD_W-1:0] r_r
);

  logic [sfa_pkg::FIELD_W:0]   s_nxt, s_r;
  sfa_pkg::op_t                kind_r;
  logic [sfa_pkg::FIELD_W:0]   up;
  logic [sfa_pkg::FIELD_W-1:0] dn;
  logic [sfa_pkg::FIELD_W-1:0] r_nxt;

  // raw sum or difference; top bit is carry or borrow
  always_comb begin
    unique case (kind)
      sfa_pkg::OP_SUB: s_nxt = {1'b0, a} - {1'b0, b};
      sfa_pkg::OP_DBL: s_nxt = {1'b0, a} + {1'b0, a};
      default:         s_nxt = {1'b0, a} + {1'b0, b};
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s_r    <= s_nxt;
      kind_r <= kind;
    end
  end

  // subtracting p mod 2^256 is adding 2^32+977; adding p is subtracting it
  assign up = {1'b0, s_r[sfa_pkg::FIELD_W-1:0]} + (sfa_pkg::FIELD_W+1)'(sfa_pkg::FOLD_C);
  assign dn = s_r[sfa_pkg::FIELD_W-1:0] - sfa_pkg::FIELD_W'(sfa_pkg::FOLD_C);

  always_comb begin
    if (kind_r == sfa_pkg::OP_SUB) begin
      r_nxt = s_r[sfa_pkg::FIELD_W] ? dn : s_r[sfa_pkg::FIELD_W-1:0];
    end else begin
      r_nxt = (s_r[sfa_pkg::FIELD_W] | up[sfa_pkg::FIELD_W]) ?
              up[sfa_pkg::FIELD_W-1:0] : s_r[sfa_pkg::FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) r_r <= r_nxt;
  end

endmodule

### rtl/core/sfa_mul.sv
// sfa_mul: three-stage 256x256 multiplier: limb products, column sums,
// final carry add. Depends on sfa_pkg.
module sfa_mul (
  input  logic                        clk,
  input  logic [2:0]                  ld,
  input  logic [sfa_pkg::FIELD_W-1:0] a,
  input  logic [sfa_pkg::FIELD_W-1:0] b,
  output logic [sfa_pkg::PROD_W-1:0]  prod_r
);

  localparam int L    = sfa_pkg::LIMB_W;
  localparam int N    = sfa_pkg::NLIMB;
  localparam int NCOL = 2 * N;
  localparam int CW   = L + 4;
  localparam int EW   = sfa_pkg::PROD_W + L;

  logic [2*L-1:0] pp_r  [N][N];
  logic [CW-1:0]  col_nxt [NCOL];
  logic [CW-1:0]  col_r   [NCOL];
  logic [EW-1:0]  ev, od, sum;

  // one 32x32 product per limb pair
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          pp_r[i][j] <= (2*L)'(a[i*L +: L]) * (2*L)'(b[j*L +: L]);
        end
      end
    end
  end

  // column k takes low halves of i+j==k and high halves of i+j==k-1
  always_comb begin
    for (int k = 0; k < NCOL; k++) begin
      col_nxt[k] = '0;
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          if (i + j == k)     col_nxt[k] = col_nxt[k] + CW'(pp_r[i][j][L-1:0]);
          if (i + j + 1 == k) col_nxt[k] = col_nxt[k] + CW'(pp_r[i][j][2*L-1:L]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) col_r <= col_nxt;
  end

  // even and odd columns do not overlap among themselves
  always_comb begin
    ev = '0;
    od = '0;
    for (int k = 0; k < NCOL; k++) begin
      if (k % 2 == 0) ev[k*L +: CW] = col_r[k];
      else            od[k*L +: CW] = col_r[k];
    end
  end

  assign sum = ev + od;

  always_ff @(posedge clk) begin
    if (ld[2]) prod_r <= sum[sfa_pkg::PROD_W-1:0];
  end

endmodule

### rtl/core/sfa_fold.sv
// sfa_fold: two-stage reduction fold, y = lo + hi * (2^32 + 977).
// Depends on sfa_pkg.
module sfa_fold #(
  parameter int IN_W  = sfa_pkg::PROD_W,
  parameter int OUT_W = sfa_pkg::F1_W
) (
  input  logic             clk,
  input  logic [1:0]       ld,
  input  logic [IN_W-1:0]  x,
  output logic [OUT_W-1:0] y_r
);

  localparam int F    = sfa_pkg::FIELD_W;
  localparam int L    = sfa_pkg::LIMB_W;
  localparam int HI_W = IN_W - F;
  localparam int NL   = (HI_W + L - 1) / L;
  localparam int HP_W = NL * L;
  localparam int MP_W = L + sfa_pkg::LOWC_W;
  localparam int PW   = HP_W + sfa_pkg::LOWC_W;
  localparam int SW   = IN_W + L;

  logic [HP_W-1:0] hi_pad;
  logic [PW-1:0]   e_nxt, o_nxt, e_r, o_r;
  logic [F-1:0]    lo_r;
  logic [HI_W-1:0] hi_r;
  logic [SW-1:0]   y_nxt;

  assign hi_pad = HP_W'(x[IN_W-1:F]);

  // hi * 977 per limb; even and odd limb products kept apart
  always_comb begin
    e_nxt = '0;
    o_nxt = '0;
    for (int k = 0; k < NL; k++) begin
      if (k % 2 == 0) e_nxt[k*L +: MP_W] = MP_W'(hi_pad[k*L +: L]) * MP_W'(sfa_pkg::FOLD_LOW);
      else            o_nxt[k*L +: MP_W] = MP_W'(hi_pad[k*L +: L]) * MP_W'(sfa_pkg::FOLD_LOW);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      lo_r <= x[F-1:0];
      hi_r <= x[IN_W-1:F];
      e_r  <= e_nxt;
      o_r  <= o_nxt;
    end
  end

  assign y_nxt = SW'(lo_r) + (SW'(hi_r) << L) + SW'(e_r) + SW'(o_r);

  always_ff @(posedge clk) begin
    if (ld[1]) y_r <= y_nxt[OUT_W-1:0];
  end

endmodule

### rtl/core/secp256k1_field_alu.sv
// secp256k1_field_alu: pipelined add/sub/double/multiply modulo p = 2^256-2^32-977.
// Beats run through all stages to out_r; one beat per cycle while out_stall is low.
// Every stage holds a valid bit; a stage loads whenever it is empty or moves on.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// Depends on sfa_pkg, sfa_addsub, sfa_mul, sfa_fold.
module secp256k1_field_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_a_word0,
  input  logic [63:0] in_a_word1,
  input  logic [63:0] in_a_word2,
  input  logic [63:0] in_a_word3,
  input  logic [63:0] in_b_word0,
  input  logic [63:0] in_b_word1,
  input  logic [63:0] in_b_word2,
  input  logic [63:0] in_b_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_r_word0,
  output logic [63:0] out_r_word1,
  output logic [63:0] out_r_word2,
  output logic [63:0] out_r_word3
);

  localparam int F = sfa_pkg::FIELD_W;
  localparam int S = sfa_pkg::NSTG;

  // Stage map:
  //   1-3  limb products, column sums, product carry add (add path: raw sum, correction)
  //   4-5  first fold, 6-7 second fold, 8-9 third fold
  //   10   final conditional subtract of p and result select into the output register
  logic [S:1]     vld_r;
  logic [S:1]     ld;
  logic [F-1:0]   a, b;
  sfa_pkg::op_t   kind;
  logic [F-1:0]   as_r;
  logic [sfa_pkg::PROD_W-1:0] prod_r;
  logic [sfa_pkg::F1_W-1:0]   f1_r;
  logic [sfa_pkg::F2_W-1:0]   f2_r;
  logic [sfa_pkg::F3_W-1:0]   f3_r;
  logic [F-1:0]   ad_r [3:S-1];
  sfa_pkg::op_t   kd_r [1:S-1];
  logic [F:0]     fin_up;
  logic [F-1:0]   mul_res;
  logic [F-1:0]   out_nxt, out_r;

  assign a    = {in_a_word3, in_a_word2, in_a_word1, in_a_word0};
  assign b    = {in_b_word3, in_b_word2, in_b_word1, in_b_word0};
  assign kind = sfa_pkg::op_t'(in_kind);

  // A stage loads when it is empty or the stage after it loads; bubbles collapse.
  always_comb begin
    ld[S] = !vld_r[S] || !out_stall;
    for (int i = S - 1; i >= 1; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
  end

  assign in_stall = !ld[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[1]) vld_r[1] <= in_valid;
      for (int i = 2; i <= S; i++) begin
        if (ld[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  sfa_addsub u_addsub (
    .clk  (clk),
    .ld   (ld[2:1]),
    .kind (kind),
    .a    (a),
    .b    (b),
    .r_r  (as_r)
  );

  sfa_mul u_mul (
    .clk    (clk),
    .ld     (ld[3:1]),
    .a      (a),
    .b      (b),
    .prod_r (prod_r)
  );

  sfa_fold #(.IN_W(sfa_pkg::PROD_W), .OUT_W(sfa_pkg::F1_W)) u_fold1 (
    .clk (clk), .ld (ld[5:4]), .x (prod_r), .y_r (f1_r)
  );

  sfa_fold #(.IN_W(sfa_pkg::F1_W), .OUT_W(sfa_pkg::F2_W)) u_fold2 (
    .clk (clk), .ld (ld[7:6]), .x (f1_r), .y_r (f2_r)
  );

  sfa_fold #(.IN_W(sfa_pkg::F2_W), .OUT_W(sfa_pkg::F3_W)) u_fold3 (
    .clk (clk), .ld (ld[9:8]), .x (f2_r), .y_r (f3_r)
  );

  // Carry the operation code alongside every beat.
  always_ff @(posedge clk) begin
    if (ld[1]) kd_r[1] <= kind;
  end

  for (genvar g = 2; g <= S - 1; g++) begin : g_kind_dly
    always_ff @(posedge clk) begin
      if (ld[g]) kd_r[g] <= kd_r[g-1];
    end
  end

  // Delay the add/sub/double result to line up with the multiply path.
  always_ff @(posedge clk) begin
    if (ld[3]) ad_r[3] <= as_r;
  end

  for (genvar g = 4; g <= S - 1; g++) begin : g_add_dly
    always_ff @(posedge clk) begin
      if (ld[g]) ad_r[g] <= ad_r[g-1];
    end
  end

  // Final step: t >= p exactly when t + 2^32 + 977 carries out of 256 bits.
  assign fin_up  = {1'b0, f3_r[F-1:0]} + (F+1)'(sfa_pkg::FOLD_C);
  assign mul_res = fin_up[F] ? fin_up[F-1:0] : f3_r[F-1:0];

  assign out_nxt = (kd_r[S-1] == sfa_pkg::OP_MUL) ? mul_res : ad_r[S-1];

  always_ff @(posedge clk) begin
    if (ld[S]) out_r <= out_nxt;
  end

  assign out_valid   = vld_r[S];
  assign out_r_word0 = out_r[63:0];
  assign out_r_word1 = out_r[127:64];
  assign out_r_word2 = out_r[191:128];
  assign out_r_word3 = out_r[255:192];

endmodule

### rtl/core/sfa_checker.sv
// sfa_checker: port-level assertions for secp256k1_field_alu, bound to the top.
// Depends on secp256k1_field_alu's port list.
module sfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_r_word0,
  input logic [63:0] out_r_word1,
  input logic [63:0] out_r_word2,
  input logic [63:0] out_r_word3
);

  // input backs up only when the output beat is held and the pipe is full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side is free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_r_word0) &&
      $stable(out_r_word1) && $stable(out_r_word2) && $stable(out_r_word3)))
    else $error("stalled output beat changed or dropped");

  // an offered beat carries a known operation code
  a_in_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_kind))
    else $error("input beat offered with unknown kind");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind secp256k1_field_alu sfa_checker u_sfa_checker (.*);

### bench/tb_secp256k1_field_alu.sv
// Testbench for secp256k1_field_alu: directed and random add, subtract, double and
// multiply beats checked against a built-in modular arithmetic predictor.
// Depends on sfa_pkg and the secp256k1_field_alu RTL.
module tb_secp256k1_field_alu;

  typedef struct {
    sfa_pkg::op_t     kind;
    logic [255:0]     a;
    logic [255:0]     b;
  } field_op_t;

  localparam logic [255:0] P_MOD = 256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEFFFFFC2F;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [63:0] in_a_word0, in_a_word1, in_a_word2, in_a_word3;
  logic [63:0] in_b_word0, in_b_word1, in_b_word2, in_b_word3;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_r_word0, out_r_word1, out_r_word2, out_r_word3;

  field_op_t    pending_ops[$];
  logic [255:0] expected_sums[$];
  int           error_count = 0;
  bit           stimulus_done;
  int           hold_off_cycles;

  secp256k1_field_alu dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the field result of one beat, following the single-correction rules
  // for add, subtract and double even when operands are not reduced.
  function automatic logic [255:0] field_result(field_op_t op);
    logic [256:0] wide;
    logic [511:0] prod;
    logic [255:0] low;
    case (op.kind)
      sfa_pkg::OP_ADD, sfa_pkg::OP_DBL: begin
        wide = {1'b0, op.a} + {1'b0, (op.kind == sfa_pkg::OP_DBL) ? op.a : op.b};
        if (wide[256] || wide[255:0] >= P_MOD) wide = wide - {1'b0, P_MOD};
        low = wide[255:0];
      end
      sfa_pkg::OP_SUB: begin
        low = op.a - op.b;
        if (op.a < op.b) low = low + P_MOD;
      end
      default: begin
        prod = {256'd0, op.a} * {256'd0, op.b};
        low = prod % {256'd0, P_MOD};
      end
    endcase
    return low;
  endfunction

  function automatic logic [255:0] rand_word256();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  // Bias operands toward the interesting corners: zero, small, near p, above p.
  function automatic logic [255:0] rand_operand();
    logic [255:0] v;
    int sel;
    sel = $urandom_range(0, 15);
    v = rand_word256();
    case (sel)
      0: v = 256'd0;
      1: v = 256'($urandom_range(0, 3));
      2: v = P_MOD - 256'($urandom_range(1, 4));
      3: v = P_MOD + 256'($urandom_range(0, 3));
      4: v = '1 - 256'($urandom_range(0, 3));
      5: v = P_MOD - {192'd0, v[63:0]};
      default: if (sel < 14 && v >= P_MOD) v = v - P_MOD;
    endcase
    return v;
  endfunction

  task automatic queue_op(sfa_pkg::op_t kind, logic [255:0] a, logic [255:0] b);
    field_op_t op;
    op.kind = kind;
    op.a = a;
    op.b = b;
    pending_ops.push_back(op);
  endtask

  // Fill the stimulus queue: directed corners first, then random beats.
  initial begin
    logic [255:0] ones;
    ones = '1;
    stimulus_done = 1'b0;
    for (int k = 0; k < 4; k++) begin
      queue_op(sfa_pkg::op_t'(k), 256'd0, 256'd0);
      queue_op(sfa_pkg::op_t'(k), P_MOD - 1, P_MOD - 1);
      queue_op(sfa_pkg::op_t'(k), P_MOD - 1, 256'd1);
      queue_op(sfa_pkg::op_t'(k), 256'd0, P_MOD - 1);
      queue_op(sfa_pkg::op_t'(k), ones, ones);
      queue_op(sfa_pkg::op_t'(k), P_MOD, 256'd1);
    end
    queue_op(sfa_pkg::OP_SUB, 256'd0, ones);
    queue_op(sfa_pkg::OP_DBL, ones, 256'd0);
    for (int i = 0; i < 1525; i++)
      queue_op(sfa_pkg::op_t'($urandom_range(0, 3)), rand_operand(), rand_operand());
  end

  // Driver: bursts of beats separated by random gaps; hold payload while stalled.
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_kind    <= '0;
      {in_a_word3, in_a_word2, in_a_word1, in_a_word0} <= '0;
      {in_b_word3, in_b_word2, in_b_word1, in_b_word0} <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        // the beat was accepted: predict it and drop it from the queue
        expected_sums.push_back(field_result(pending_ops[0]));
        void'(pending_ops.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_valid   <= 1'b1;
        in_kind    <= pending_ops[0].kind;
        {in_a_word3, in_a_word2, in_a_word1, in_a_word0} <= pending_ops[0].a;
        {in_b_word3, in_b_word2, in_b_word1, in_b_word0} <= pending_ops[0].b;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
        if (pending_ops.size() == 0) stimulus_done <= 1'b1;
      end
    end
  end

  // Receiver stall pattern: quiet stretches, random stalls, and one long hold-off
  // early on so the pipeline fills and pushes back on the sender.
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall       <= 1'b0;
      stall_phase     <= 0;
      hold_off_cycles <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase >= 100 && stall_phase < 160) begin
        out_stall       <= 1'b1;
        hold_off_cycles <= hold_off_cycles + 1;
      end else if ((stall_phase / 200) % 3 == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Monitor: compare each accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    logic [255:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result beat r=%h",
               {out_r_word3, out_r_word2, out_r_word1, out_r_word0});
        error_count++;
      end else begin
        want = expected_sums.pop_front();
        if (out_r_word0 !== want[63:0]) begin
          $error("r_word0 expected %h actual %h", want[63:0], out_r_word0);
          error_count++;
        end
        if (out_r_word1 !== want[127:64]) begin
          $error("r_word1 expected %h actual %h", want[127:64], out_r_word1);
          error_count++;
        end
        if (out_r_word2 !== want[191:128]) begin
          $error("r_word2 expected %h actual %h", want[191:128], out_r_word2);
          error_count++;
        end
        if (out_r_word3 !== want[255:192]) begin
          $error("r_word3 expected %h actual %h", want[255:192], out_r_word3);
          error_count++;
        end
      end
    end
  end

  // Reset, then wait for the stimulus to drain and the pipeline to settle.
  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && expected_sums.size() == 0);
    repeat (sfa_pkg::NSTG + 20) @(posedge clk);
    if (error_count == 0 && expected_sums.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
